FILE: src/fdnpr_pkg.sv
// ----------------------------------------------------------------------------
// fdnpr_pkg
// Shared types and constants of the feedback delay network plate reverb.
// ----------------------------------------------------------------------------
package fdnpr_pkg;

  localparam int unsigned NUM_LINES = 8;
  localparam int unsigned SAMPLE_W  = 24;
  // Shared multiplier: operands wide enough for a Householder mix term.
  localparam int unsigned MUL_W     = 27;
  localparam int unsigned PROD_W    = 2 * MUL_W;

  // Base delay lengths in milliseconds.
  localparam int unsigned LINE_MS [NUM_LINES] = '{37, 87, 181, 271, 359, 449, 563, 641};

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] mul_prod_t;

endpackage

FILE: src/fdnpr_ram.sv
// ----------------------------------------------------------------------------
// fdnpr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fdnpr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/fdnpr_mul.sv
// ----------------------------------------------------------------------------
// fdnpr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fdnpr_mul (
  input  logic                clk,
  input  fdnpr_pkg::mul_op_t  a,
  input  fdnpr_pkg::mul_op_t  b,
  output fdnpr_pkg::mul_prod_t p
);

  fdnpr_pkg::mul_prod_t p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

FILE: src/fdn_plate_reverb.sv
// ----------------------------------------------------------------------------
// fdn_plate_reverb
// Eight-line feedback delay network reverb with per-line biquad damping and
// Householder feedback mix; delay lines live in one shared RAM.
// ----------------------------------------------------------------------------
//  channel | handshake            | content
//  in_     | tvalid/tready        | tuser: cmd; tdata: sample, line, coef sel, coef
//  out_    | tvalid/tready        | tdata: sample_out
//  cfg_    | APB write/read       | 0x0 feedback_gain, 0x4 time_scale
//
// An audio sample runs per line through 8 steps on the single shared multiplier
// (tap length, five biquad products), then 2 steps per line for the feedback
// writes and 3 for the output. A coefficient load is taken in idle and written.
// Reset is synchronous; delay RAM contents count as zero until the write
// pointer has passed them once, so no clearing pass is run.
// A result held by out_tready stalls only the final step of the next sample.
// ----------------------------------------------------------------------------
module fdn_plate_reverb #(
  parameter int unsigned SAMPLE_RATE_HZ = 48000,
  parameter int unsigned LINE_DEPTH     = 28800
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // sample_in[23:0], line_sel[26:24], coeff_sel[29:27],
                                  // coeff_value[53:30], zero fill
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // sample_out[23:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned NL      = fdnpr_pkg::NUM_LINES;
  localparam int unsigned MW      = fdnpr_pkg::MUL_W;
  localparam int unsigned WIDE_W  = fdnpr_pkg::PROD_W + 2;
  localparam int unsigned WP_W    = $clog2(LINE_DEPTH);
  localparam int unsigned ADDR_W  = $clog2(NL * LINE_DEPTH);
  localparam int unsigned DL_W    = 19;

  localparam int unsigned BASE_LEN [NL] = '{
    fdnpr_pkg::LINE_MS[0] * SAMPLE_RATE_HZ / 1000,
    fdnpr_pkg::LINE_MS[1] * SAMPLE_RATE_HZ / 1000,
    fdnpr_pkg::LINE_MS[2] * SAMPLE_RATE_HZ / 1000,
    fdnpr_pkg::LINE_MS[3] * SAMPLE_RATE_HZ / 1000,
    fdnpr_pkg::LINE_MS[4] * SAMPLE_RATE_HZ / 1000,
    fdnpr_pkg::LINE_MS[5] * SAMPLE_RATE_HZ / 1000,
    fdnpr_pkg::LINE_MS[6] * SAMPLE_RATE_HZ / 1000,
    fdnpr_pkg::LINE_MS[7] * SAMPLE_RATE_HZ / 1000
  };

  localparam logic signed [WIDE_W-1:0] S24_HI = WIDE_W'(64'sd8388607);
  localparam logic signed [WIDE_W-1:0] S24_LO = WIDE_W'(-64'sd8388608);
  localparam logic signed [WIDE_W-1:0] RND22  = WIDE_W'(64'sd2097152);
  localparam logic signed [WIDE_W-1:0] RND15  = WIDE_W'(64'sd16384);
  localparam logic signed [23:0]       COEF_ONE = 24'sd4194304;
  localparam logic signed [MW-1:0]     DRY_Q15  = MW'(3277);
  localparam logic signed [MW-1:0]     WET_Q15  = MW'(29491);
  localparam logic [14:0]              GAIN_RST = 15'd16463;
  localparam logic [13:0]              TS_RST   = 14'd4096;
  localparam logic                     CMD_LOAD = 1'b1;
  localparam logic                     REG_GAIN = 1'b0;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef struct packed {
    logic signed [23:0] b0;
    logic signed [23:0] b1;
    logic signed [23:0] b2;
    logic signed [23:0] a1;
    logic signed [23:0] a2;
  } coef_row_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DLY, ST_ADR, ST_TAP, ST_Y, ST_A1, ST_B2, ST_A2, ST_S2,
    ST_MG, ST_MWR, ST_O1, ST_O2, ST_OUT
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [WIDE_W-1:0] v);
    if (v > S24_HI) begin
      return 24'sh7FFFFF;
    end else if (v < S24_LO) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  state_t                    state_r;
  coef_row_t                 coef_r  [NL];
  logic signed [23:0]        s1_r    [NL];
  logic signed [23:0]        s2_r    [NL];
  logic signed [23:0]        taps_r  [NL];
  logic [14:0]               gain_r;
  logic [13:0]               tscale_r;
  logic [WP_W-1:0]           wp_r;
  logic                      wrapped_r;
  logic [2:0]                line_r;
  logic [ADDR_W-1:0]         line_base_r;
  logic signed [23:0]        x_r;
  logic signed [23:0]        tap_r;
  logic signed [23:0]        y_r;
  logic signed [MW-1:0]      sum_r;
  fdnpr_pkg::mul_prod_t      acc_r;
  logic                      tap_ok_r;
  logic                      out_valid_r;
  logic [23:0]               out_data_r;

  fdnpr_pkg::mul_op_t        mul_a;
  fdnpr_pkg::mul_op_t        mul_b;
  fdnpr_pkg::mul_prod_t      prod;

  logic                      in_fire;
  logic                      cfg_wr;
  logic [DL_W-1:0]           dly_raw;
  logic [WP_W-1:0]           dly;
  logic [WP_W:0]             addr_sum;
  logic [WP_W-1:0]           tap_addr;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [23:0]               ram_rdata;
  logic signed [23:0]        ram_wdata;
  logic                      ram_we;
  logic signed [23:0]        tap_now;
  logic signed [MW-1:0]      quarter;
  logic signed [MW-1:0]      mix;
  logic signed [WIDE_W-1:0]  prod_w;
  logic signed [WIDE_W-1:0]  acc_w;
  coef_row_t                 coef_cur;
  logic                      last_line;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_GAIN) ? {17'd0, gain_r} : {18'd0, tscale_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign coef_cur  = coef_r[line_r];
  assign last_line = (line_r == 3'(NL - 1));
  assign prod_w    = WIDE_W'(prod);
  assign acc_w     = WIDE_W'(acc_r);
  assign quarter   = sum_r >>> 2;
  assign mix       = MW'(taps_r[line_r]) - quarter;
  assign tap_now   = tap_ok_r ? signed'(ram_rdata) : 24'sd0;

  // Tap length: clamp the scaled base length, then wrap behind the pointer.
  always_comb begin
    dly_raw = prod[DL_W+11:12];
    if (dly_raw == '0) begin
      dly = WP_W'(1);
    end else if (dly_raw > DL_W'(LINE_DEPTH - 1)) begin
      dly = WP_W'(LINE_DEPTH - 1);
    end else begin
      dly = dly_raw[WP_W-1:0];
    end
    addr_sum = {1'b0, wp_r} + (WP_W+1)'(LINE_DEPTH) - {1'b0, dly};
    if (addr_sum >= (WP_W+1)'(LINE_DEPTH)) begin
      addr_sum = addr_sum - (WP_W+1)'(LINE_DEPTH);
    end
    tap_addr = addr_sum[WP_W-1:0];
  end

  assign ram_raddr = line_base_r + ADDR_W'(tap_addr);
  assign ram_waddr = line_base_r + ADDR_W'(wp_r);
  assign ram_we    = (state_r == ST_MWR);
  assign ram_wdata = sat24(WIDE_W'(x_r) + ((prod_w + RND15) >>> 15));

  always_comb begin
    case (state_r)
      ST_DLY: begin
        mul_a = MW'(BASE_LEN[line_r]);
        mul_b = MW'(tscale_r);
      end
      ST_TAP: begin
        mul_a = MW'(tap_now);
        mul_b = MW'(coef_cur.b0);
      end
      ST_Y: begin
        mul_a = MW'(tap_r);
        mul_b = MW'(coef_cur.b1);
      end
      ST_A1: begin
        mul_a = MW'(y_r);
        mul_b = MW'(coef_cur.a1);
      end
      ST_B2: begin
        mul_a = MW'(tap_r);
        mul_b = MW'(coef_cur.b2);
      end
      ST_A2: begin
        mul_a = MW'(y_r);
        mul_b = MW'(coef_cur.a2);
      end
      ST_MG: begin
        mul_a = mix;
        mul_b = MW'(gain_r);
      end
      ST_O1: begin
        mul_a = MW'(x_r);
        mul_b = DRY_Q15;
      end
      ST_O2, ST_OUT: begin
        mul_a = sum_r;
        mul_b = WET_Q15;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fdnpr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  fdnpr_ram #(
    .WIDTH (24),
    .DEPTH (NL * LINE_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= GAIN_RST;
      tscale_r    <= TS_RST;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      line_r      <= '0;
      line_base_r <= '0;
      for (int i = 0; i < NL; i++) begin
        coef_r[i] <= '{b0: COEF_ONE, default: '0};
        s1_r[i]   <= '0;
        s2_r[i]   <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_GAIN) begin
          gain_r <= cfg_pwdata[14:0];
        end else begin
          tscale_r <= cfg_pwdata[13:0];
        end
      end
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_tuser == CMD_LOAD) begin
              case (coef_sel_t'(in_tdata[29:27]))
                COEF_B0: coef_r[in_tdata[26:24]].b0 <= in_tdata[53:30];
                COEF_B1: coef_r[in_tdata[26:24]].b1 <= in_tdata[53:30];
                COEF_B2: coef_r[in_tdata[26:24]].b2 <= in_tdata[53:30];
                COEF_A1: coef_r[in_tdata[26:24]].a1 <= in_tdata[53:30];
                COEF_A2: coef_r[in_tdata[26:24]].a2 <= in_tdata[53:30];
                default: ;
              endcase
            end else begin
              x_r         <= in_tdata[23:0];
              sum_r       <= '0;
              line_r      <= '0;
              line_base_r <= '0;
              state_r     <= ST_DLY;
            end
          end
        end
        ST_DLY: state_r <= ST_ADR;
        ST_ADR: begin
          // Entries not yet passed by the write pointer read as zero.
          tap_ok_r <= wrapped_r || (tap_addr < wp_r);
          state_r  <= ST_TAP;
        end
        ST_TAP: begin
          tap_r   <= tap_now;
          state_r <= ST_Y;
        end
        ST_Y: begin
          y_r     <= sat24(((prod_w + RND22) >>> 22) + WIDE_W'(s1_r[line_r]));
          state_r <= ST_A1;
        end
        ST_A1: begin
          acc_r   <= prod;
          state_r <= ST_B2;
        end
        ST_B2: begin
          s1_r[line_r] <= sat24(((acc_w - prod_w + RND22) >>> 22) + WIDE_W'(s2_r[line_r]));
          state_r      <= ST_A2;
        end
        ST_A2: begin
          acc_r   <= prod;
          state_r <= ST_S2;
        end
        ST_S2: begin
          s2_r[line_r]   <= sat24((acc_w - prod_w + RND22) >>> 22);
          taps_r[line_r] <= y_r;
          sum_r          <= sum_r + MW'(y_r);
          line_r         <= line_r + 3'd1;
          if (last_line) begin
            line_base_r <= '0;
            state_r     <= ST_MG;
          end else begin
            line_base_r <= line_base_r + ADDR_W'(LINE_DEPTH);
            state_r     <= ST_DLY;
          end
        end
        ST_MG: state_r <= ST_MWR;
        ST_MWR: begin
          line_r      <= line_r + 3'd1;
          line_base_r <= line_base_r + ADDR_W'(LINE_DEPTH);
          state_r     <= last_line ? ST_O1 : ST_MG;
        end
        ST_O1: state_r <= ST_O2;
        ST_O2: begin
          acc_r   <= prod;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free.
          if (!out_valid_r || out_tready) begin
            out_data_r  <= sat24((acc_w - prod_w + RND15) >>> 15);
            out_valid_r <= 1'b1;
            if (wp_r == WP_W'(LINE_DEPTH - 1)) begin
              wp_r      <= '0;
              wrapped_r <= 1'b1;
            end else begin
              wp_r <= wp_r + WP_W'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
